>>> rtl/core/sps_pkg.sv
// shared types and constants of the seeded permutation shuffle
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

	typedef struct packed {
		logic [6:0]  element_count;
		logic [63:0] seed;
	} job_t;

	typedef struct packed {
		logic [5:0] position;
		logic [5:0] entry_value;
		logic       last;
	} result_t;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
	localparam int          SHIFT_A    = 30;
	localparam int          SHIFT_B    = 27;
	localparam int          SHIFT_C    = 31;

	// width of the generator output fed to the remainder unit
	localparam int DVD_W = 64;

endpackage

`default_nettype wire

>>> rtl/core/sps_front.sv
// front end: accepts jobs, saturates the count, drops empty jobs, two-entry job queue
`timescale 1ns / 1ps
`default_nettype none

module sps_front #(
	parameter int MAX_COUNT = 64,
	parameter int CNT_W     = 7
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               job_valid,
	output logic              job_stall,
	input  sps_pkg::job_t     job,
	output logic              q_valid,
	input  wire               q_pop,
	output logic [CNT_W-1:0]  q_count,
	output logic [63:0]       q_seed
);
	import sps_pkg::*;

	localparam int NW = (CNT_W > 7) ? CNT_W : 7;

	logic [NW-1:0]    cnt_ext;
	logic [NW-1:0]    cnt_sat;
	logic             accept;
	logic             push;
	logic [1:0]       fill_q;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [CNT_W-1:0] count_q [2];
	logic [63:0]      seed_q  [2];

	always_comb begin
		cnt_ext = NW'(job.element_count);
		cnt_sat = (cnt_ext > NW'(MAX_COUNT)) ? NW'(MAX_COUNT) : cnt_ext;
	end

	assign job_stall = (fill_q == 2'd2);
	assign accept    = job_valid && !job_stall;
	// a zero count produces nothing, so it never enters the queue
	assign push      = accept && (job.element_count != '0);

	assign q_valid = (fill_q != 2'd0);
	assign q_count = count_q[rd_ptr_q];
	assign q_seed  = seed_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			count_q[wr_ptr_q] <= cnt_sat[CNT_W-1:0];
			seed_q[wr_ptr_q]  <= job.seed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (push && !q_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sps_gen.sv
// splitmix64 generator built around one shared 32x32 multiplier
`timescale 1ns / 1ps
`default_nettype none

module sps_gen (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         load,
	input  wire  [63:0] seed,
	input  wire         step,
	output logic        done,
	output logic [63:0] result
);
	import sps_pkg::*;

	typedef enum logic [4:0] {
		G_IDLE = 5'b00001,
		G_MULA = 5'b00010,
		G_XORB = 5'b00100,
		G_MULB = 5'b01000,
		G_FIN  = 5'b10000
	} gen_state_t;

	gen_state_t  fsm_q;
	logic [1:0]  phase_q;
	logic [63:0] rng_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [63:0] rng_next;
	logic [63:0] mul_k;
	logic [31:0] op_z;
	logic [31:0] op_k;
	logic [63:0] prod;

	assign rng_next = rng_q + GOLDEN_INC;
	assign mul_k    = (fsm_q == G_MULB) ? MIX_MUL_B : MIX_MUL_A;

	// low 64 bits of z*k: zl*kl + ((zl*kh + zh*kl) << 32), one partial product a cycle
	always_comb begin
		op_z = (phase_q == 2'd2) ? z_q[63:32] : z_q[31:0];
		op_k = (phase_q == 2'd1) ? mul_k[63:32] : mul_k[31:0];
		prod = op_z * op_k;
	end

	assign done   = (fsm_q == G_FIN);
	assign result = acc_q ^ (acc_q >> SHIFT_C);

	always_ff @(posedge clk) begin
		unique case (fsm_q)
			G_IDLE: begin
				if (step) begin
					z_q <= rng_next ^ (rng_next >> SHIFT_A);
				end
			end
			G_MULA, G_MULB: begin
				if (phase_q == 2'd0) begin
					acc_q <= prod;
				end else begin
					acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				end
			end
			G_XORB: begin
				z_q <= acc_q ^ (acc_q >> SHIFT_B);
			end
			G_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= G_IDLE;
			phase_q <= 2'd0;
			rng_q   <= '0;
		end else begin
			unique case (fsm_q)
				G_IDLE: begin
					phase_q <= 2'd0;
					priority if (load) begin
						rng_q <= seed;
					end else if (step) begin
						rng_q <= rng_next;
						fsm_q <= G_MULA;
					end
				end
				G_MULA: begin
					if (phase_q == 2'd2) begin
						phase_q <= 2'd0;
						fsm_q   <= G_XORB;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				G_XORB: begin
					fsm_q <= G_MULB;
				end
				G_MULB: begin
					if (phase_q == 2'd2) begin
						phase_q <= 2'd0;
						fsm_q   <= G_FIN;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				G_FIN: begin
					fsm_q <= G_IDLE;
				end
				default: begin
					fsm_q <= G_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sps_mod.sv
// bit-serial restoring remainder of a 64-bit value by a small divisor
`timescale 1ns / 1ps
`default_nettype none

module sps_mod #(
	parameter int CNT_W = 7
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire  [63:0]      dividend,
	input  wire  [CNT_W-1:0] divisor,
	output logic             done,
	output logic [CNT_W-1:0] remainder
);
	import sps_pkg::*;

	localparam int BIT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W-1:0] rem_q;
	logic [BIT_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;

	// remainder stays below the divisor, so the trial stays below twice it
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		ge    = (trial >= {1'b0, div_q});
		diff  = trial - {1'b0, div_q};
	end

	assign done      = done_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + BIT_W'(1);
				if (bit_q == BIT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sps_back.sv
// back end: permutation store, fill / shuffle / emit sequencer, output register
`timescale 1ns / 1ps
`default_nettype none

module sps_back #(
	parameter int MAX_COUNT = 64,
	parameter int IDX_W     = 6,
	parameter int CNT_W     = 7
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	output logic                q_pop,
	input  wire  [CNT_W-1:0]    q_count,
	input  wire  [63:0]         q_seed,
	output logic                result_valid,
	input  wire                 result_stall,
	output sps_pkg::result_t    result
);
	import sps_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_FILL = 9'b000000010,
		S_STEP = 9'b000000100,
		S_GEN  = 9'b000001000,
		S_MOD  = 9'b000010000,
		S_RD   = 9'b000100000,
		S_WRI  = 9'b001000000,
		S_WRJ  = 9'b010000000,
		S_EMRD = 9'b100000000
	} seq_state_t;

	// emit write-out reuses read port a: S_EMRD reads the store in E_OFF, then waits in E_WAIT for the output register
	typedef enum logic [1:0] {
		E_OFF  = 2'b01,
		E_WAIT = 2'b10
	} emit_state_t;

	seq_state_t       st_q;
	emit_state_t      em_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic             last_k;

	logic [IDX_W-1:0] mem [MAX_COUNT];
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] wdata;
	logic             rd_en;
	logic [IDX_W-1:0] ra_addr;
	logic [IDX_W-1:0] rb_addr;
	logic [IDX_W-1:0] rda_q;
	logic [IDX_W-1:0] rdb_q;

	logic             gen_load;
	logic             gen_step;
	logic             gen_done;
	logic [63:0]      gen_result;
	logic             mod_start;
	logic             mod_done;
	logic [CNT_W-1:0] mod_rem;

	logic             out_load;
	logic             result_valid_q;
	result_t          result_q;

	sps_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (gen_load),
		.seed   (q_seed),
		.step   (gen_step),
		.done   (gen_done),
		.result (gen_result)
	);

	sps_mod #(
		.CNT_W (CNT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (gen_result),
		.divisor   (CNT_W'(i_q) + CNT_W'(1)),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign last_k       = (CNT_W'(k_q) == (n_q - CNT_W'(1)));
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rda_q <= mem[ra_addr];
			rdb_q <= mem[rb_addr];
		end
	end

	always_comb begin
		we        = 1'b0;
		waddr     = k_q;
		wdata     = k_q;
		rd_en     = 1'b0;
		ra_addr   = i_q;
		rb_addr   = j_q;
		q_pop     = 1'b0;
		gen_load  = 1'b0;
		gen_step  = 1'b0;
		mod_start = 1'b0;
		out_load  = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				q_pop    = q_valid;
				gen_load = q_valid;
			end
			S_FILL: begin
				we = 1'b1;
			end
			S_STEP: begin
				gen_step = 1'b1;
			end
			S_GEN: begin
				mod_start = gen_done;
			end
			S_MOD: begin
			end
			S_RD: begin
				rd_en = 1'b1;
			end
			S_WRI: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdb_q;
			end
			S_WRJ: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = rda_q;
			end
			S_EMRD: begin
				if (em_q == E_OFF) begin
					rd_en   = 1'b1;
					ra_addr = k_q;
				end else begin
					out_load = !result_valid_q || !result_stall;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				n_q <= q_count;
				k_q <= '0;
			end
			S_FILL: begin
				if (last_k) begin
					i_q <= IDX_W'(n_q - CNT_W'(1));
					k_q <= '0;
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			S_MOD: begin
				if (mod_done) begin
					j_q <= mod_rem[IDX_W-1:0];
				end
			end
			S_WRJ: begin
				i_q <= i_q - IDX_W'(1);
			end
			S_EMRD: begin
				if (out_load) begin
					result_q.position    <= 6'(k_q);
					result_q.entry_value <= 6'(rda_q);
					result_q.last        <= last_k;
					k_q                  <= k_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			em_q           <= E_OFF;
			result_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						st_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (last_k) begin
						// a single entry needs no swap
						st_q <= (n_q == CNT_W'(1)) ? S_EMRD : S_STEP;
						em_q <= E_OFF;
					end
				end
				S_STEP: begin
					st_q <= S_GEN;
				end
				S_GEN: begin
					if (gen_done) begin
						st_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						st_q <= S_RD;
					end
				end
				S_RD: begin
					st_q <= S_WRI;
				end
				S_WRI: begin
					st_q <= S_WRJ;
				end
				S_WRJ: begin
					st_q <= (i_q == IDX_W'(1)) ? S_EMRD : S_STEP;
					em_q <= E_OFF;
				end
				S_EMRD: begin
					unique case (em_q)
						E_OFF: begin
							em_q <= E_WAIT;
						end
						E_WAIT: begin
							if (out_load) begin
								em_q <= E_OFF;
								if (last_k) begin
									st_q <= S_IDLE;
								end
							end
						end
						default: begin
							em_q <= E_OFF;
						end
					endcase
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/seeded_permutation_shuffle_top.sv
// top level of the seeded permutation shuffle
`timescale 1ns / 1ps
`default_nettype none

// each job item carries an element count n (0..127, saturated to MAX_COUNT) and a
// 64-bit seed. the block fills its store with 0..n-1, runs a swap-based random shuffle
// driven by splitmix64 (for i = n-1 down to 1, j = next % (i+1), swap i and j) and
// then returns n result items in position order, with last set on the final one. a
// count of zero returns nothing. a front queue holds up to two pending jobs, so new
// jobs are taken while the back end shuffles or while a result waits on result_stall.
// for each job the store is filled first. with n >= 2 each swap then runs the generator
// and then the bit-serial remainder unit (one bit of the 64-bit generator output per
// cycle); a job with n = 1 skips the swaps. each result is then read from the store
// and waits for the output register. the generator shares one 32x32 multiplier over
// the two 64-bit mixing products. the store is not cleared: every job writes each
// entry it reads before reading it.

module seeded_permutation_shuffle_top #(
	parameter int MAX_COUNT = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               job_valid,
	output logic              job_stall,
	input  sps_pkg::job_t     job,
	output logic              result_valid,
	input  wire               result_stall,
	output sps_pkg::result_t  result
);
	import sps_pkg::*;

	// store address width and width of a count 0..MAX_COUNT
	localparam int IDX_W = $clog2(MAX_COUNT);
	localparam int CNT_W = $clog2(MAX_COUNT + 1);

	// job queue between the front and back ends
	logic             q_valid;
	logic             q_pop;
	logic [CNT_W-1:0] q_count;
	logic [63:0]      q_seed;

	// front: takes jobs, saturates the count, drops empty ones
	sps_front #(
		.MAX_COUNT (MAX_COUNT),
		.CNT_W     (CNT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_stall (job_stall),
		.job       (job),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_count   (q_count),
		.q_seed    (q_seed)
	);

	// back: fill, shuffle and emit one job at a time
	sps_back #(
		.MAX_COUNT (MAX_COUNT),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_count      (q_count),
		.q_seed       (q_seed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> rtl/core/sps_checker.sv
// port-level checks of the seeded permutation shuffle and their bind
`timescale 1ns / 1ps
`default_nettype none

module sps_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              job_valid,
	input wire              job_stall,
	input sps_pkg::job_t    job,
	input wire              result_valid,
	input wire              result_stall,
	input sps_pkg::result_t result
);
	import sps_pkg::*;

	logic       job_take;
	logic       res_take;
	logic       job_counts;
	logic       res_done;
	logic [5:0] exp_pos_q;
	logic       first_q;
	logic [2:0] pending_q;

	assign job_take   = job_valid && !job_stall;
	assign res_take   = result_valid && !result_stall;
	assign job_counts = job_take && (job.element_count != '0);
	assign res_done   = res_take && result.last;

	// expected position and number of jobs whose results are not all out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pos_q <= '0;
			first_q   <= 1'b1;
			pending_q <= '0;
		end else begin
			if (res_take) begin
				exp_pos_q <= result.last ? 6'd0 : exp_pos_q + 6'd1;
				first_q   <= result.last;
			end
			priority if (job_counts && !res_done) begin
				pending_q <= pending_q + 3'd1;
			end else if (!job_counts && res_done) begin
				pending_q <= pending_q - 3'd1;
			end
		end
	end

	a_pos_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.position == exp_pos_q))
		else $error("result position out of sequence");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pending_q != 3'd0))
		else $error("result without a pending job");

	a_single_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && first_q && result.last) |-> (result.entry_value == 6'd0))
		else $error("one-entry permutation is not the identity");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

endmodule

bind seeded_permutation_shuffle_top sps_checker u_sps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.job_valid    (job_valid),
	.job_stall    (job_stall),
	.job          (job),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

>>> tb/sv/tb_seeded_permutation_shuffle_top.sv
// testbench of the seeded permutation shuffle: directed and random jobs checked against a shuffle predictor
`timescale 1ns / 1ps

module tb_seeded_permutation_shuffle_top;

	import sps_pkg::*;

	localparam int          ENTRIES    = 64;
	localparam int          STUCK_MAX  = 30000;
	localparam int          DRAIN_WAIT = 200;
	// splitmix64 step constants
	localparam logic [63:0] STEP_INC   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_A      = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_B      = 64'h94D0_49BB_1331_11EB;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    job_valid    = 1'b0;
	logic    job_stall;
	job_t    job          = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// jobs not yet taken by the block, and entries it still owes
	job_t    pending_jobs[$];
	result_t expected_entries[$];

	// predictor state: shuffle store and generator
	logic [5:0]  perm_store [ENTRIES];
	logic [63:0] mix_state = '0;

	// idle rates in percent, changed per phase
	int unsigned send_idle_pct = 19;
	int unsigned recv_idle_pct = 50;

	// set at the rising edge when the job on the port was taken
	bit          job_fired   = 1'b0;
	int unsigned fail_count  = 0;
	int unsigned stuck_count = 0;

	seeded_permutation_shuffle_top #(
		.MAX_COUNT(ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.job(job),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one splitmix64 step: advance the state, mix, return the output
	function automatic logic [63:0] advance_mix();
		logic [63:0] z;
		mix_state = mix_state + STEP_INC;
		z = mix_state;
		z = (z ^ (z >> 30)) * MIX_A;
		z = (z ^ (z >> 27)) * MIX_B;
		return z ^ (z >> 31);
	endfunction

	// swap shuffle over 0..n-1, then queue the n entries in position order
	task automatic shuffle_job(input job_t j);
		int          n;
		logic [63:0] draw;
		logic [63:0] divisor;
		int          pick;
		logic [5:0]  held;
		result_t     entry;
		mix_state = j.seed;
		// counts above the store size saturate
		n = (j.element_count > ENTRIES) ? ENTRIES : int'(j.element_count);
		for (int i = 0; i < n; i++)
			perm_store[i] = 6'(i);
		for (int i = n - 1; i > 0; i--) begin
			draw = advance_mix();
			divisor = 64'(i + 1);
			pick = int'(draw % divisor);
			held = perm_store[i];
			perm_store[i] = perm_store[pick];
			perm_store[pick] = held;
		end
		for (int i = 0; i < n; i++) begin
			entry.position = 6'(i);
			entry.entry_value = perm_store[i];
			entry.last = (i == n - 1);
			expected_entries.push_back(entry);
		end
	endtask

	task automatic add_job(input int count, input logic [63:0] seed);
		job_t j;
		j.element_count = 7'(count);
		j.seed = seed;
		pending_jobs.push_back(j);
	endtask

	// mostly short runs so the bit-serial remainder stays cheap, a few full and saturated ones
	function automatic int random_count();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 0;
		else if (roll < 16)
			return 1;
		else if (roll < 70)
			return $urandom_range(12, 2);
		else if (roll < 90)
			return $urandom_range(40, 13);
		else if (roll < 96)
			return $urandom_range(64, 41);
		return $urandom_range(127, 65);
	endfunction

	function automatic logic [63:0] random_seed();
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return 64'($urandom_range(255));
		else if (roll == 1)
			return ~64'($urandom_range(255));
		return {$urandom, $urandom};
	endfunction

	task automatic add_random_jobs(input int amount);
		for (int k = 0; k < amount; k++)
			add_job(random_count(), random_seed());
	endtask

	// let every queued job go in and every owed entry come out
	task automatic drain();
		while (pending_jobs.size() != 0 || expected_entries.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// job driver: a held item keeps its payload until taken, otherwise it may idle
	always @(negedge clk) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
		end else if (job_valid && !job_fired) begin
			// still waiting on the block, leave the item as it is
		end else if (pending_jobs.size() == 0 || $urandom_range(99) < send_idle_pct) begin
			job_valid <= 1'b0;
		end else begin
			job_valid <= 1'b1;
			job <= pending_jobs[0];
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// monitor: predict on each taken job, check each taken result in order
	always @(posedge clk) begin
		result_t want;
		job_fired = arst_n && job_valid && !job_stall;
		if (job_fired) begin
			shuffle_job(job);
			void'(pending_jobs.pop_front());
		end
		if (arst_n && result_valid && !result_stall) begin
			if (expected_entries.size() == 0) begin
				$error("unexpected result item: position %0d entry_value %0d last %0b",
					result.position, result.entry_value, result.last);
				fail_count++;
			end else begin
				want = expected_entries.pop_front();
				if (result.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, result.position);
					fail_count++;
				end
				if (result.entry_value !== want.entry_value) begin
					$error("entry_value: expected %0d, got %0d",
						want.entry_value, result.entry_value);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	// watchdog: fails the run when neither port moves for too long, allowing for a full 64-entry shuffle
	always @(posedge clk) begin
		if (!arst_n || (job_valid && !job_stall) || (result_valid && !result_stall))
			stuck_count = 0;
		else
			stuck_count++;
		if (stuck_count >= STUCK_MAX) begin
			$display("FAIL seeded_permutation_shuffle_top");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed jobs: empty, single, tiny, full, saturated counts and edge seeds
		add_job(0, 64'h0);
		add_job(0, '1);
		add_job(1, 64'h0);
		add_job(1, '1);
		add_job(2, 64'h0);
		add_job(2, '1);
		add_job(3, 64'h8000_0000_0000_0000);
		add_job(4, 64'h0123_4567_89AB_CDEF);
		add_job(5, 64'h5555_5555_5555_5555);
		add_job(7, 64'hAAAA_AAAA_AAAA_AAAA);
		add_job(16, 64'h0000_0000_0000_0001);
		add_job(63, 64'hFEDC_BA98_7654_3210);
		add_job(64, 64'h0);
		add_job(64, '1);
		add_job(65, {$urandom, $urandom});
		add_job(100, {$urandom, $urandom});
		add_job(127, {$urandom, $urandom});
		// an empty job between two shuffles must not disturb either
		add_job(6, {$urandom, $urandom});
		add_job(0, {$urandom, $urandom});
		add_job(6, {$urandom, $urandom});

		// phase one: sender idles now and then, receiver half the time
		add_random_jobs(37);
		drain();

		// phase two: the other way round
		send_idle_pct = 50;
		recv_idle_pct = 19;
		add_random_jobs(37);
		drain();

		// phase three: full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_jobs(36);
		drain();

		// catch anything the block sends after the last owed entry
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_entries.size() != 0) begin
			$error("%0d result items never arrived", expected_entries.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS seeded_permutation_shuffle_top");
		else
			$display("FAIL seeded_permutation_shuffle_top");
		$finish;
	end

endmodule

>>> files.f
rtl/core/sps_pkg.sv
rtl/core/sps_front.sv
rtl/core/sps_gen.sv
rtl/core/sps_mod.sv
rtl/core/sps_back.sv
rtl/core/seeded_permutation_shuffle_top.sv
rtl/core/sps_checker.sv
tb/sv/tb_seeded_permutation_shuffle_top.sv
